[rtl/imusd_pkg.sv]
// ----------------------------------------------------------------------------
// imusd_pkg: shared types and constants of the IMU static detector
// Window geometry, datapath widths, status and register codes, lane control.
// ----------------------------------------------------------------------------
`default_nettype none

package imusd_pkg;

   localparam int WINDOW          = 32;
   localparam int SAMPLE_BITS     = 16;
   localparam int LIMIT_BITS      = 16;
   localparam int STEP_LIMIT_BITS = 17;
   localparam int AXES            = 6;
   localparam int GYRO_AXES       = 3;
   localparam int MASK_BITS       = 10;

   localparam int SLOT_BITS  = $clog2(WINDOW);
   localparam int FILL_BITS  = $clog2(WINDOW + 1);
   localparam int SUM_BITS   = SAMPLE_BITS + SLOT_BITS + 1;
   localparam int SQ_BITS    = 2 * SAMPLE_BITS - 1;
   localparam int SQS_BITS   = SQ_BITS + SLOT_BITS;
   localparam int PAIR_COUNT = WINDOW * (WINDOW - 1);
   localparam int PAIR_BITS  = $clog2(PAIR_COUNT + 1);
   localparam int T_BITS     = 2 * LIMIT_BITS + PAIR_BITS;
   // holds N*sum(x^2), sum(x)^2 and sum(x)^2 plus the scaled limit
   localparam int CMP_BITS   = 2 * SUM_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = STEP_LIMIT_BITS;

   // result queue, depth a power of two
   localparam int RSP_DEPTH    = 8;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int CREDIT_BITS  = $clog2(RSP_DEPTH + 1);

   localparam int PIPE_STAGES = 5;

   localparam int MASK_NORM         = 0;
   localparam int MASK_STEP         = 1;
   localparam int MASK_GYRO_Z       = 2;
   localparam int MASK_ACCEL_Y      = 3;
   localparam int MASK_GYRO_SPREAD  = 4;
   localparam int MASK_ACCEL_SPREAD = 7;

   typedef logic signed [SAMPLE_BITS-1:0] axis_type;

   typedef enum logic [1:0] {
      STATUS_FILLING = 2'd0,
      STATUS_STATIC  = 2'd1,
      STATUS_MOVING  = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GYRO_NORM    = 3'd0,
      CSR_ACCEL_STEP   = 3'd1,
      CSR_GYRO_Z       = 3'd2,
      CSR_ACCEL_Y      = 3'd3,
      CSR_GYRO_SPREAD  = 3'd4,
      CSR_ACCEL_SPREAD = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [2*LIMIT_BITS-1:0]    norm_sq;
      logic [STEP_LIMIT_BITS-1:0] step;
      logic [LIMIT_BITS-1:0]      gyro_z;
      logic [LIMIT_BITS-1:0]      accel_y;
      logic [T_BITS-1:0]          gyro_t;
      logic [T_BITS-1:0]          accel_t;
   } lim_type;

   typedef struct packed {
      logic                 accept;
      logic                 full;
      logic [SLOT_BITS-1:0] slot;
   } lane_ctl_type;

   typedef struct packed {
      logic accel_y;
      logic gyro_z;
      logic step;
      logic norm;
   } motion_type;

endpackage

`default_nettype wire

[rtl/imusd_if.sv]
// ----------------------------------------------------------------------------
// imusd_if: channel interfaces of the IMU static detector
// Sample input, status output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface imusd_req_if import imusd_pkg::*; ();
   logic     valid;
   logic     ready;
   axis_type gyro_x;
   axis_type gyro_y;
   axis_type gyro_z;
   axis_type accel_x;
   axis_type accel_y;
   axis_type accel_z;

   modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                   input ready);
   modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                 output ready);
endinterface

interface imusd_rsp_if import imusd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [MASK_BITS-1:0] pass_mask;

   modport source (output valid, status, pass_mask, input ready);
   modport sink (input valid, status, pass_mask, output ready);
endinterface

interface imusd_csr_if import imusd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/imusd_csr.sv]
// ----------------------------------------------------------------------------
// imusd_csr: limit registers and derived thresholds
// Holds the six limits and precomputes squared and window-scaled forms.
// ----------------------------------------------------------------------------
`default_nettype none

module imusd_csr import imusd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   imusd_csr_if.sink csr_chan,
   output lim_type limits
);

   logic [LIMIT_BITS-1:0]      norm_lim_ff;
   logic [STEP_LIMIT_BITS-1:0] step_lim_ff;
   logic [LIMIT_BITS-1:0]      gz_lim_ff;
   logic [LIMIT_BITS-1:0]      ay_lim_ff;
   logic [LIMIT_BITS-1:0]      gspread_ff;
   logic [LIMIT_BITS-1:0]      aspread_ff;
   logic [2*LIMIT_BITS-1:0]    norm_sq_ff;
   logic [2*LIMIT_BITS-1:0]    gsq_ff;
   logic [2*LIMIT_BITS-1:0]    asq_ff;
   logic [T_BITS-1:0]          gyro_t_ff;
   logic [T_BITS-1:0]          accel_t_ff;
   logic                       wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_lim_ff <= '0;
         step_lim_ff <= '0;
         gz_lim_ff   <= '0;
         ay_lim_ff   <= '0;
         gspread_ff  <= '0;
         aspread_ff  <= '0;
         norm_sq_ff  <= '0;
         gsq_ff      <= '0;
         asq_ff      <= '0;
         gyro_t_ff   <= '0;
         accel_t_ff  <= '0;
      end else begin
         if (wr_en) begin
            unique case (csr_index_type'(csr_chan.index))
               CSR_GYRO_NORM:    norm_lim_ff <= csr_chan.data[LIMIT_BITS-1:0];
               CSR_ACCEL_STEP:   step_lim_ff <= csr_chan.data[STEP_LIMIT_BITS-1:0];
               CSR_GYRO_Z:       gz_lim_ff   <= csr_chan.data[LIMIT_BITS-1:0];
               CSR_ACCEL_Y:      ay_lim_ff   <= csr_chan.data[LIMIT_BITS-1:0];
               CSR_GYRO_SPREAD:  gspread_ff  <= csr_chan.data[LIMIT_BITS-1:0];
               CSR_ACCEL_SPREAD: aspread_ff  <= csr_chan.data[LIMIT_BITS-1:0];
               default: ;
            endcase
         end
         // two-step derivation, settled long before an item reaches the compares
         norm_sq_ff <= norm_lim_ff * norm_lim_ff;
         gsq_ff     <= gspread_ff * gspread_ff;
         asq_ff     <= aspread_ff * aspread_ff;
         gyro_t_ff  <= T_BITS'(gsq_ff) * T_BITS'(PAIR_COUNT);
         accel_t_ff <= T_BITS'(asq_ff) * T_BITS'(PAIR_COUNT);
      end
   end

   assign limits.norm_sq = norm_sq_ff;
   assign limits.step    = step_lim_ff;
   assign limits.gyro_z  = gz_lim_ff;
   assign limits.accel_y = ay_lim_ff;
   assign limits.gyro_t  = gyro_t_ff;
   assign limits.accel_t = accel_t_ff;

endmodule

`default_nettype wire

[rtl/imusd_lane.sv]
// ----------------------------------------------------------------------------
// imusd_lane: one axis of the sliding window
// Ring store of the axis, running sum and sum of squares, spread compare.
// ----------------------------------------------------------------------------
`default_nettype none

module imusd_lane import imusd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  lane_ctl_type      ctl,
   input  axis_type          sample,
   input  logic [T_BITS-1:0] thresh,
   output logic              pass
);

   axis_type                        win_mem [WINDOW];
   axis_type                        smp_ff;
   axis_type                        old_ff;
   axis_type                        old_m;
   logic                            s0_vld_ff;
   logic                            s0_full_ff;
   logic signed [2*SAMPLE_BITS-1:0] vsq_full;
   logic signed [2*SAMPLE_BITS-1:0] osq_full;
   logic [SQ_BITS-1:0]              vsq_ff, vsq_in;
   logic [SQ_BITS-1:0]              osq_ff, osq_in;
   logic signed [SAMPLE_BITS:0]     dv_ff, dv_in;
   logic signed [SUM_BITS-1:0]      sum_ff;
   logic [SQS_BITS-1:0]             sqs_ff;
   logic signed [2*SUM_BITS-1:0]    ssq_full;
   logic [CMP_BITS-1:0]             ssq_ff;
   logic [CMP_BITS-1:0]             lhs_ff;
   logic                            pass_ff;

   // oldest entry is read before the new item overwrites its slot
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         smp_ff            <= sample;
         old_ff            <= win_mem[ctl.slot];
         win_mem[ctl.slot] <= sample;
      end
   end

   assign old_m = s0_full_ff ? old_ff : '0;

   always_comb begin
      vsq_full = smp_ff * smp_ff;
      osq_full = old_m * old_m;
      vsq_in   = '0;
      osq_in   = '0;
      dv_in    = '0;
      if (s0_vld_ff) begin
         vsq_in = vsq_full[SQ_BITS-1:0];
         osq_in = osq_full[SQ_BITS-1:0];
         dv_in  = (SAMPLE_BITS+1)'(smp_ff) - (SAMPLE_BITS+1)'(old_m);
      end
      ssq_full = sum_ff * sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff  <= 1'b0;
         s0_full_ff <= 1'b0;
         vsq_ff     <= '0;
         osq_ff     <= '0;
         dv_ff      <= '0;
         sum_ff     <= '0;
         sqs_ff     <= '0;
      end else begin
         s0_vld_ff  <= ctl.accept;
         s0_full_ff <= ctl.accept && ctl.full;
         vsq_ff     <= vsq_in;
         osq_ff     <= osq_in;
         dv_ff      <= dv_in;
         // idle cycles add zero
         sum_ff     <= sum_ff + SUM_BITS'(dv_ff);
         sqs_ff     <= sqs_ff + SQS_BITS'(vsq_ff) - SQS_BITS'(osq_ff);
      end
   end

   // N*sum(x^2) - sum(x)^2 < lim^2*N*(N-1), rearranged to stay unsigned
   always_ff @(posedge clock) begin
      ssq_ff  <= CMP_BITS'($unsigned(ssq_full));
      lhs_ff  <= CMP_BITS'(sqs_ff) * CMP_BITS'(WINDOW);
      pass_ff <= lhs_ff < (ssq_ff + CMP_BITS'(thresh));
   end

   assign pass = pass_ff;

endmodule

`default_nettype wire

[rtl/imusd_motion.sv]
// ----------------------------------------------------------------------------
// imusd_motion: per-sample motion tests
// Gyro norm, accel x/y step against the previous sample, |gz| and |ay|.
// ----------------------------------------------------------------------------
`default_nettype none

module imusd_motion import imusd_pkg::*; (
   input  logic       clock,
   input  logic       accept,
   input  axis_type   gyro_x,
   input  axis_type   gyro_y,
   input  axis_type   gyro_z,
   input  axis_type   accel_x,
   input  axis_type   accel_y,
   input  lim_type    limits,
   output motion_type result
);

   axis_type                        gx_ff, gy_ff, gz_ff;
   axis_type                        ax_ff, ay_ff;
   axis_type                        pax_ff, pay_ff;
   axis_type                        prev_ax_ff, prev_ay_ff;
   logic signed [2*SAMPLE_BITS-1:0] gxx_full, gyy_full, gzz_full;
   logic [SQ_BITS-1:0]              gxx_ff, gyy_ff, gzz_ff;
   logic signed [SAMPLE_BITS:0]     dax_ff, day_ff;
   logic [SAMPLE_BITS-1:0]          gz_mag, ay_mag;
   logic [SAMPLE_BITS:0]            dax_mag, day_mag;
   logic                            gz_ok1_ff, ay_ok1_ff;
   logic                            gz_ok2_ff, ay_ok2_ff;
   logic [2*SAMPLE_BITS:0]          norm_ff;
   logic [SAMPLE_BITS+1:0]          step_ff;
   motion_type                      res3_in, res3_ff, result_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         gx_ff      <= gyro_x;
         gy_ff      <= gyro_y;
         gz_ff      <= gyro_z;
         ax_ff      <= accel_x;
         ay_ff      <= accel_y;
         pax_ff     <= prev_ax_ff;
         pay_ff     <= prev_ay_ff;
         prev_ax_ff <= accel_x;
         prev_ay_ff <= accel_y;
      end
   end

   always_comb begin
      gxx_full = gx_ff * gx_ff;
      gyy_full = gy_ff * gy_ff;
      gzz_full = gz_ff * gz_ff;
      gz_mag   = gz_ff[SAMPLE_BITS-1] ? $unsigned(-gz_ff) : $unsigned(gz_ff);
      ay_mag   = ay_ff[SAMPLE_BITS-1] ? $unsigned(-ay_ff) : $unsigned(ay_ff);
      dax_mag  = dax_ff[SAMPLE_BITS] ? $unsigned(-dax_ff) : $unsigned(dax_ff);
      day_mag  = day_ff[SAMPLE_BITS] ? $unsigned(-day_ff) : $unsigned(day_ff);
      res3_in.norm    = norm_ff < (2*SAMPLE_BITS+1)'(limits.norm_sq);
      res3_in.step    = step_ff < (SAMPLE_BITS+2)'(limits.step);
      res3_in.gyro_z  = gz_ok2_ff;
      res3_in.accel_y = ay_ok2_ff;
   end

   always_ff @(posedge clock) begin
      // squares, differences, single-axis limits
      gxx_ff    <= gxx_full[SQ_BITS-1:0];
      gyy_ff    <= gyy_full[SQ_BITS-1:0];
      gzz_ff    <= gzz_full[SQ_BITS-1:0];
      dax_ff    <= (SAMPLE_BITS+1)'(ax_ff) - (SAMPLE_BITS+1)'(pax_ff);
      day_ff    <= (SAMPLE_BITS+1)'(ay_ff) - (SAMPLE_BITS+1)'(pay_ff);
      gz_ok1_ff <= (LIMIT_BITS+1)'(gz_mag) < (LIMIT_BITS+1)'(limits.gyro_z);
      ay_ok1_ff <= (LIMIT_BITS+1)'(ay_mag) < (LIMIT_BITS+1)'(limits.accel_y);
      // sums
      norm_ff   <= (2*SAMPLE_BITS+1)'(gxx_ff) + (2*SAMPLE_BITS+1)'(gyy_ff)
                   + (2*SAMPLE_BITS+1)'(gzz_ff);
      step_ff   <= (SAMPLE_BITS+2)'(dax_mag) + (SAMPLE_BITS+2)'(day_mag);
      gz_ok2_ff <= gz_ok1_ff;
      ay_ok2_ff <= ay_ok1_ff;
      // compares, then one register to line up with the spread lanes
      res3_ff   <= res3_in;
      result_ff <= res3_ff;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

[rtl/imu_static_detector.sv]
// ----------------------------------------------------------------------------
// imu_static_detector: zero-velocity detector over a sliding IMU window
// Six axis lanes keep running window sums; a merge stage forms the status.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one six-axis sample per item (signed raw counts).
//   rsp_chan returns one item per sample: status (filling, static, moving)
//   and the ten-bit pass mask. csr_chan writes the six limits, always ready;
//   it must be written only while no item is outstanding (not enforced here).
// Timing:
//   A sample's result passes the lane and motion pipelines, then the result
//   queue, before it shows on rsp_chan. One item is accepted every cycle
//   while req_chan.ready is high: each lane updates its running sum and
//   sum of squares once per cycle, and the window store of each lane is
//   read and written at the same slot in the cycle an item is accepted.
// Stall:
//   Results wait in an 8-entry queue. req_chan.ready drops once 8 items are
//   accepted but not yet taken, so a stalled receiver loses nothing.
// Reset:
//   Clears the limits, sums, fill count, queue and pipeline; the window
//   then fills again and the first WINDOW-1 results report filling.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_static_detector import imusd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   imusd_req_if.sink   req_chan,
   imusd_rsp_if.source rsp_chan,
   imusd_csr_if.sink   csr_chan
);

   lim_type                 lim;
   lane_ctl_type            lane_ctl;
   motion_type              motion;
   axis_type                smp [AXES];
   logic [AXES-1:0]         spread_pass;
   logic                    req_accept;
   logic                    rsp_accept;
   logic [FILL_BITS-1:0]    fill_ff;
   logic [SLOT_BITS-1:0]    slot_ff;
   logic [PIPE_STAGES-1:0]  vld_ff;
   logic [PIPE_STAGES-1:0]  win_ff;
   logic [CREDIT_BITS-1:0]  credit_ff, credit_in;
   logic [CREDIT_BITS-1:0]  q_cnt_ff, q_cnt_in;
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   status_type              q_status_ff [RSP_DEPTH];
   logic [MASK_BITS-1:0]    q_mask_ff [RSP_DEPTH];
   logic [MASK_BITS-1:0]    mask_raw, mask_in;
   status_type              status_in;
   logic                    q_push;

   imusd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .limits   (lim)
   );

   assign req_chan.ready = credit_ff < CREDIT_BITS'(RSP_DEPTH);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_accept     = rsp_chan.valid && rsp_chan.ready;

   assign smp[0] = req_chan.gyro_x;
   assign smp[1] = req_chan.gyro_y;
   assign smp[2] = req_chan.gyro_z;
   assign smp[3] = req_chan.accel_x;
   assign smp[4] = req_chan.accel_y;
   assign smp[5] = req_chan.accel_z;

   assign lane_ctl.accept = req_accept;
   assign lane_ctl.full   = fill_ff == FILL_BITS'(WINDOW);
   assign lane_ctl.slot   = slot_ff;

   for (genvar g = 0; g < AXES; g++) begin : g_lane
      imusd_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .sample (smp[g]),
         .thresh ((g < GYRO_AXES) ? lim.gyro_t : lim.accel_t),
         .pass   (spread_pass[g])
      );
   end

   imusd_motion u_motion (
      .clock   (clock),
      .accept  (req_accept),
      .gyro_x  (req_chan.gyro_x),
      .gyro_y  (req_chan.gyro_y),
      .gyro_z  (req_chan.gyro_z),
      .accel_x (req_chan.accel_x),
      .accel_y (req_chan.accel_y),
      .limits  (lim),
      .result  (motion)
   );

   // merge the lane and motion results of the item leaving the pipeline
   always_comb begin
      mask_raw = '0;
      mask_raw[MASK_NORM]    = motion.norm;
      mask_raw[MASK_STEP]    = motion.step;
      mask_raw[MASK_GYRO_Z]  = motion.gyro_z;
      mask_raw[MASK_ACCEL_Y] = motion.accel_y;
      for (int i = 0; i < GYRO_AXES; i++) begin
         mask_raw[MASK_GYRO_SPREAD + i]  = spread_pass[i];
         mask_raw[MASK_ACCEL_SPREAD + i] = spread_pass[GYRO_AXES + i];
      end
      if (win_ff[PIPE_STAGES-1]) begin
         mask_in   = mask_raw;
         status_in = (&mask_raw) ? STATUS_STATIC : STATUS_MOVING;
      end else begin
         mask_in   = '0;
         status_in = STATUS_FILLING;
      end
   end

   assign q_push = vld_ff[PIPE_STAGES-1];

   always_comb begin
      credit_in = credit_ff;
      case ({req_accept, rsp_accept})
         2'b10:   credit_in = credit_ff + 1'b1;
         2'b01:   credit_in = credit_ff - 1'b1;
         default: credit_in = credit_ff;
      endcase
      q_cnt_in = q_cnt_ff;
      case ({q_push, rsp_accept})
         2'b10:   q_cnt_in = q_cnt_ff + 1'b1;
         2'b01:   q_cnt_in = q_cnt_ff - 1'b1;
         default: q_cnt_in = q_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         slot_ff   <= '0;
         vld_ff    <= '0;
         win_ff    <= '0;
         credit_ff <= '0;
         q_cnt_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (req_accept) begin
            if (fill_ff != FILL_BITS'(WINDOW)) begin
               fill_ff <= fill_ff + 1'b1;
            end
            slot_ff <= (slot_ff == SLOT_BITS'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         end
         vld_ff    <= {vld_ff[PIPE_STAGES-2:0], req_accept};
         win_ff    <= {win_ff[PIPE_STAGES-2:0],
                       req_accept && (fill_ff >= FILL_BITS'(WINDOW - 1))};
         credit_ff <= credit_in;
         q_cnt_ff  <= q_cnt_in;
         if (q_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_accept) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_status_ff[wr_ptr_ff] <= status_in;
         q_mask_ff[wr_ptr_ff]   <= mask_in;
      end
   end

   assign rsp_chan.valid     = q_cnt_ff != '0;
   assign rsp_chan.status    = q_status_ff[rd_ptr_ff];
   assign rsp_chan.pass_mask = q_mask_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[rtl/imusd_checker.sv]
// ----------------------------------------------------------------------------
// imusd_checker: port-level checks of the IMU static detector
// Result ordering against the window fill, status coding, output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module imusd_checker import imusd_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           rsp_status,
   input logic [MASK_BITS-1:0] rsp_pass_mask
);

   logic [CREDIT_BITS-1:0] outstanding_ff;
   logic [FILL_BITS-1:0]   delivered_ff;
   logic                   req_acc;
   logic                   rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         delivered_ff   <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + CREDIT_BITS'(req_acc)
                           - CREDIT_BITS'(rsp_acc);
         if (rsp_acc && (delivered_ff != FILL_BITS'(WINDOW - 1))) begin
            delivered_ff <= delivered_ff + 1'b1;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_pass_mask))
      else $error("result item changed while stalled");

   a_fill_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FILLING) |-> rsp_pass_mask == '0)
      else $error("filling item with nonzero pass mask");

   a_static_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_FILLING) |->
         (rsp_status == STATUS_STATIC || rsp_status == STATUS_MOVING) &&
         ((rsp_status == STATUS_STATIC) == (rsp_pass_mask == '1)))
      else $error("status does not match pass mask");

   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0) &&
         ((delivered_ff < FILL_BITS'(WINDOW - 1)) == (rsp_status == STATUS_FILLING)))
      else $error("result item without sample or wrong filling status");

endmodule

bind imu_static_detector imusd_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.status),
   .rsp_pass_mask (rsp_chan.pass_mask)
);

`default_nettype wire
